FILE: rtl/rect_clip_split_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for rect_clip_split
// Shared helpers for concurrent checks clocked by clk_i and reset by rst_ni.
// ----------------------------------------------------------------------------
`ifndef RECT_CLIP_SPLIT_MACROS_SVH
`define RECT_CLIP_SPLIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RCS_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define RCS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/rcs_pkg.sv
// ----------------------------------------------------------------------------
// Rectangle clip and split package
// Coordinate, rectangle and job types shared by the front, queue and back.
// ----------------------------------------------------------------------------
package rcs_pkg;

  localparam int COORD_BITS = 16;

  localparam int QDEPTH     = 2;
  localparam int QPTR_BITS  = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_BITS  = $clog2(QDEPTH + 1);

  localparam int NUM_CUTS   = 4;
  localparam int CUT_LEFT   = 0;
  localparam int CUT_TOP    = 1;
  localparam int CUT_RIGHT  = 2;
  localparam int CUT_BOTTOM = 3;

  typedef logic signed [COORD_BITS-1:0] coord_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] top;
    logic signed [COORD_BITS-1:0] left;
    logic signed [COORD_BITS-1:0] bottom;
    logic signed [COORD_BITS-1:0] right;
  } box_t;

  typedef struct packed {
    logic                split;
    logic                overlap;
    logic [NUM_CUTS-1:0] cuts;
    box_t                subj;
    box_t                clip;
  } job_t;

endpackage

FILE: rtl/rcs_front.sv
// ----------------------------------------------------------------------------
// Rectangle clip and split front end
// Accepts request beats and classifies them: overlap test and cut mask.
// ----------------------------------------------------------------------------
module rcs_front import rcs_pkg::*; (
  input  logic   in_valid_i,
  output logic   in_ready_o,
  input  logic   req_type_i,
  input  coord_t subj_top_i,
  input  coord_t subj_left_i,
  input  coord_t subj_bottom_i,
  input  coord_t subj_right_i,
  input  coord_t clip_top_i,
  input  coord_t clip_left_i,
  input  coord_t clip_bottom_i,
  input  coord_t clip_right_i,
  output logic   job_valid_o,
  input  logic   job_ready_i,
  output job_t   job_o
);

  logic   cut_left, cut_top, cut_right, cut_bottom;
  coord_t left_mid, top_mid;

  // The left cut narrows the subject before the right test, the top cut
  // before the bottom test.
  always_comb begin
    cut_left   = (clip_left_i >= subj_left_i) && (clip_left_i <= subj_right_i);
    left_mid   = cut_left ? clip_left_i : subj_left_i;
    cut_top    = (clip_top_i >= subj_top_i) && (clip_top_i <= subj_bottom_i);
    top_mid    = cut_top ? clip_top_i : subj_top_i;
    cut_right  = (clip_right_i >= left_mid) && (clip_right_i <= subj_right_i);
    cut_bottom = (clip_bottom_i >= top_mid) && (clip_bottom_i <= subj_bottom_i);
  end

  always_comb begin
    job_o.split                = req_type_i;
    job_o.overlap              = (subj_left_i <= clip_right_i) &&
                                 (subj_right_i >= clip_left_i) &&
                                 (subj_top_i <= clip_bottom_i) &&
                                 (subj_bottom_i >= clip_top_i);
    job_o.cuts                 = '0;
    job_o.cuts[CUT_LEFT]       = cut_left;
    job_o.cuts[CUT_TOP]        = cut_top;
    job_o.cuts[CUT_RIGHT]      = cut_right;
    job_o.cuts[CUT_BOTTOM]     = cut_bottom;
    job_o.subj.top             = subj_top_i;
    job_o.subj.left            = subj_left_i;
    job_o.subj.bottom          = subj_bottom_i;
    job_o.subj.right           = subj_right_i;
    job_o.clip.top             = clip_top_i;
    job_o.clip.left            = clip_left_i;
    job_o.clip.bottom          = clip_bottom_i;
    job_o.clip.right           = clip_right_i;
  end

  assign job_valid_o = in_valid_i;
  assign in_ready_o  = job_ready_i;

endmodule

FILE: rtl/rcs_queue.sv
// ----------------------------------------------------------------------------
// Rectangle clip and split job queue
// Short FIFO of classified jobs between the front end and the back end.
// ----------------------------------------------------------------------------
module rcs_queue import rcs_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_valid_i,
  output logic push_ready_o,
  input  job_t push_job_i,
  output logic pop_valid_o,
  input  logic pop_ready_i,
  output job_t pop_job_o
);

  job_t                 mem_q [QDEPTH];
  logic [QPTR_BITS-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_BITS-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_BITS-1:0] count_q, count_d;
  logic                 push, pop;

  assign push_ready_o = (count_q != QCNT_BITS'(QDEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign pop_job_o    = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == QPTR_BITS'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == QPTR_BITS'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_job_i;
    end
  end

endmodule

FILE: rtl/rcs_back.sv
// ----------------------------------------------------------------------------
// Rectangle clip and split back end
// Issues the job's result beats to the output register, one per cycle barring
// stalls: one for intersect, one per cut piece for split (one if none is cut).
// ----------------------------------------------------------------------------
module rcs_back import rcs_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   job_valid_i,
  output logic   job_ready_o,
  input  job_t   job_i,
  output logic   out_valid_o,
  input  logic   out_ready_i,
  output coord_t piece_top_o,
  output coord_t piece_left_o,
  output coord_t piece_bottom_o,
  output coord_t piece_right_o,
  output logic   piece_present_o,
  output logic   last_piece_o
);

  logic                busy_q, busy_d;
  logic                split_q;
  logic                overlap_q;
  logic [NUM_CUTS-1:0] rem_q, rem_d;
  box_t                subj_q, subj_d;
  box_t                clip_q;

  logic                out_valid_q, out_valid_d;
  box_t                piece_q;
  logic                present_q;
  logic                last_q;

  logic                adv, done, load;
  box_t                piece;
  logic                present;
  logic                last;
  box_t                merged;
  logic [NUM_CUTS-1:0] rem_next;

  assign adv  = busy_q && (!out_valid_q || out_ready_i);
  assign done = adv && last;
  assign load = job_valid_i && (!busy_q || done);
  assign job_ready_o = !busy_q || done;

  always_comb begin
    merged = subj_q;
    if (rem_q[CUT_LEFT]) begin
      merged.left = clip_q.left;
    end
    if (rem_q[CUT_TOP]) begin
      merged.top = clip_q.top;
    end
    if (rem_q[CUT_RIGHT]) begin
      merged.right = clip_q.right;
    end
    if (rem_q[CUT_BOTTOM]) begin
      merged.bottom = clip_q.bottom;
    end
  end

  always_comb begin
    piece    = '0;
    present  = 1'b0;
    last     = 1'b1;
    subj_d   = subj_q;
    rem_next = '0;
    if (!split_q) begin
      present = overlap_q;
      piece   = overlap_q ? merged : '0;
    end else if (rem_q != '0) begin
      present  = 1'b1;
      piece    = subj_q;
      rem_next = rem_q & (rem_q - 1'b1);
      last     = (rem_next == '0);
      if (rem_q[CUT_LEFT]) begin
        piece.right = coord_t'(clip_q.left - coord_t'(1));
        subj_d.left = clip_q.left;
      end else if (rem_q[CUT_TOP]) begin
        piece.bottom = coord_t'(clip_q.top - coord_t'(1));
        subj_d.top   = clip_q.top;
      end else if (rem_q[CUT_RIGHT]) begin
        piece.left   = coord_t'(clip_q.right + coord_t'(1));
        subj_d.right = clip_q.right;
      end else begin
        piece.top     = coord_t'(clip_q.bottom + coord_t'(1));
        subj_d.bottom = clip_q.bottom;
      end
    end
  end

  always_comb begin
    busy_d = busy_q;
    rem_d  = rem_q;
    if (load) begin
      busy_d = 1'b1;
      rem_d  = job_i.cuts;
    end else if (done) begin
      busy_d = 1'b0;
    end else if (adv) begin
      rem_d = rem_next;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (adv) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      rem_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      rem_q       <= rem_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      split_q   <= job_i.split;
      overlap_q <= job_i.overlap;
      subj_q    <= job_i.subj;
      clip_q    <= job_i.clip;
    end else if (adv) begin
      subj_q <= subj_d;
    end
    if (adv) begin
      piece_q   <= piece;
      present_q <= present;
      last_q    <= last;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign piece_top_o     = piece_q.top;
  assign piece_left_o    = piece_q.left;
  assign piece_bottom_o  = piece_q.bottom;
  assign piece_right_o   = piece_q.right;
  assign piece_present_o = present_q;
  assign last_piece_o    = last_q;

endmodule

FILE: rtl/rect_clip_split.sv
// ----------------------------------------------------------------------------
// Rectangle clip and split
// Intersects a subject rectangle with a clip rectangle, or splits the subject
// into the pieces that lie outside the clip rectangle.
// ----------------------------------------------------------------------------
// The block takes one request beat per cycle while its two-entry job queue
// has room. Each request yields one to four result beats, the last one marked
// by last_piece_o. The back end issues one result beat per cycle while the
// output is not stalled: one beat for an intersect request and one per cut
// piece for a split request (one beat when nothing is cut). With the block
// idle, the first result beat of a request passes the job queue, the back
// end's job registers and its output register before it is presented.
`include "rect_clip_split_macros.svh"

module rect_clip_split import rcs_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   in_valid_i,
  output logic   in_ready_o,
  input  logic   req_type_i,
  input  coord_t subj_top_i,
  input  coord_t subj_left_i,
  input  coord_t subj_bottom_i,
  input  coord_t subj_right_i,
  input  coord_t clip_top_i,
  input  coord_t clip_left_i,
  input  coord_t clip_bottom_i,
  input  coord_t clip_right_i,
  output logic   out_valid_o,
  input  logic   out_ready_i,
  output coord_t piece_top_o,
  output coord_t piece_left_o,
  output coord_t piece_bottom_o,
  output coord_t piece_right_o,
  output logic   piece_present_o,
  output logic   last_piece_o
);

  logic fq_valid, fq_ready;
  job_t fq_job;
  logic qb_valid, qb_ready;
  job_t qb_job;
  logic empty_beat;
  logic zero_edges;
  logic mid_beat;

  rcs_front u_front (
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .req_type_i    (req_type_i),
    .subj_top_i    (subj_top_i),
    .subj_left_i   (subj_left_i),
    .subj_bottom_i (subj_bottom_i),
    .subj_right_i  (subj_right_i),
    .clip_top_i    (clip_top_i),
    .clip_left_i   (clip_left_i),
    .clip_bottom_i (clip_bottom_i),
    .clip_right_i  (clip_right_i),
    .job_valid_o   (fq_valid),
    .job_ready_i   (fq_ready),
    .job_o         (fq_job)
  );

  rcs_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (fq_valid),
    .push_ready_o (fq_ready),
    .push_job_i   (fq_job),
    .pop_valid_o  (qb_valid),
    .pop_ready_i  (qb_ready),
    .pop_job_o    (qb_job)
  );

  rcs_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .job_valid_i     (qb_valid),
    .job_ready_o     (qb_ready),
    .job_i           (qb_job),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .piece_top_o     (piece_top_o),
    .piece_left_o    (piece_left_o),
    .piece_bottom_o  (piece_bottom_o),
    .piece_right_o   (piece_right_o),
    .piece_present_o (piece_present_o),
    .last_piece_o    (last_piece_o)
  );

  assign empty_beat = out_valid_o && !piece_present_o;
  assign zero_edges = (piece_top_o == '0) && (piece_left_o == '0) &&
                      (piece_bottom_o == '0) && (piece_right_o == '0);
  assign mid_beat   = out_valid_o && out_ready_i && !last_piece_o;

  `RCS_ASSERT_SAME(a_empty_is_last, empty_beat, last_piece_o, "empty beat not last")
  `RCS_ASSERT_SAME(a_empty_is_zero, empty_beat, zero_edges, "empty beat has edges")
  `RCS_ASSERT_SAME(a_full_queue, !in_ready_o, qb_valid, "front stalled with idle queue")
  `RCS_ASSERT_NEXT(a_pieces_follow, mid_beat, out_valid_o, "gap inside a split result")

endmodule

FILE: verif/rect_clip_split_tb.sv
// ----------------------------------------------------------------------------
// Testbench for rect_clip_split
// Sends intersect and split requests with random gaps on both handshakes,
// except in the back-to-back run, works out the expected pieces for each
// accepted request beat and checks every result beat against them in order.
// ----------------------------------------------------------------------------
module rect_clip_split_tb;
  import rcs_pkg::*;

  typedef enum logic {
    REQ_INTERSECT = 1'b0,
    REQ_SPLIT     = 1'b1
  } req_kind_e;

  typedef struct {
    coord_t top;
    coord_t left;
    coord_t bottom;
    coord_t right;
    logic   present;
    logic   is_last;
  } piece_t;

  logic   clk_i;
  logic   rst_ni        = 1'b0;
  logic   in_valid_i    = 1'b0;
  logic   req_type_i    = 1'b0;
  coord_t subj_top_i    = '0;
  coord_t subj_left_i   = '0;
  coord_t subj_bottom_i = '0;
  coord_t subj_right_i  = '0;
  coord_t clip_top_i    = '0;
  coord_t clip_left_i   = '0;
  coord_t clip_bottom_i = '0;
  coord_t clip_right_i  = '0;
  logic   out_ready_i   = 1'b0;
  logic   in_ready_o;
  logic   out_valid_o;
  coord_t piece_top_o;
  coord_t piece_left_o;
  coord_t piece_bottom_o;
  coord_t piece_right_o;
  logic   piece_present_o;
  logic   last_piece_o;

  piece_t pending_pieces[$];
  int     fail_count = 0;
  bit     no_gaps    = 1'b0;

  rect_clip_split uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .req_type_i     (req_type_i),
    .subj_top_i     (subj_top_i),
    .subj_left_i    (subj_left_i),
    .subj_bottom_i  (subj_bottom_i),
    .subj_right_i   (subj_right_i),
    .clip_top_i     (clip_top_i),
    .clip_left_i    (clip_left_i),
    .clip_bottom_i  (clip_bottom_i),
    .clip_right_i   (clip_right_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .piece_top_o    (piece_top_o),
    .piece_left_o   (piece_left_o),
    .piece_bottom_o (piece_bottom_o),
    .piece_right_o  (piece_right_o),
    .piece_present_o(piece_present_o),
    .last_piece_o   (last_piece_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #4_000_000;
    $display("** rect_clip_split: FAILED **");
    $finish;
  end

  function automatic box_t rect(int t, int l, int b, int r);
    box_t bx;
    bx.top    = coord_t'(t);
    bx.left   = coord_t'(l);
    bx.bottom = coord_t'(b);
    bx.right  = coord_t'(r);
    return bx;
  endfunction

  function automatic coord_t jitter(int c, int spread);
    return coord_t'(c + int'($urandom_range(0, 2 * spread)) - spread);
  endfunction

  function automatic int draw_wait();
    return no_gaps ? 0 : int'($urandom_range(0, 14));
  endfunction

  function automatic bit in_span(coord_t v, coord_t lo, coord_t hi);
    return v >= lo && v <= hi;
  endfunction

  function automatic void add_piece(box_t bx, logic present);
    piece_t pc;
    pc.top     = present ? bx.top : '0;
    pc.left    = present ? bx.left : '0;
    pc.bottom  = present ? bx.bottom : '0;
    pc.right   = present ? bx.right : '0;
    pc.present = present;
    pc.is_last = 1'b0;
    pending_pieces.push_back(pc);
  endfunction

  function automatic void predict_pieces(req_kind_e kind, box_t subj, box_t clip);
    box_t cur;
    box_t cut;
    int   n0;
    cur = subj;
    n0  = pending_pieces.size();
    if (kind == REQ_INTERSECT) begin
      if (cur.left <= clip.right && cur.right >= clip.left &&
          cur.top <= clip.bottom && cur.bottom >= clip.top) begin
        if (in_span(clip.left, cur.left, cur.right)) cur.left = clip.left;
        if (in_span(clip.top, cur.top, cur.bottom)) cur.top = clip.top;
        if (in_span(clip.right, cur.left, cur.right)) cur.right = clip.right;
        if (in_span(clip.bottom, cur.top, cur.bottom)) cur.bottom = clip.bottom;
        add_piece(cur, 1'b1);
      end
    end else begin
      if (in_span(clip.left, cur.left, cur.right)) begin
        cut       = cur;
        cut.right = clip.left - 16'sd1;
        add_piece(cut, 1'b1);
        cur.left  = clip.left;
      end
      if (in_span(clip.top, cur.top, cur.bottom)) begin
        cut        = cur;
        cut.bottom = clip.top - 16'sd1;
        add_piece(cut, 1'b1);
        cur.top    = clip.top;
      end
      if (in_span(clip.right, cur.left, cur.right)) begin
        cut       = cur;
        cut.left  = clip.right + 16'sd1;
        add_piece(cut, 1'b1);
        cur.right = clip.right;
      end
      if (in_span(clip.bottom, cur.top, cur.bottom)) begin
        cut        = cur;
        cut.top    = clip.bottom + 16'sd1;
        add_piece(cut, 1'b1);
        cur.bottom = clip.bottom;
      end
    end
    if (pending_pieces.size() == n0) add_piece(cur, 1'b0);
    pending_pieces[pending_pieces.size() - 1].is_last = 1'b1;
  endfunction

  function automatic void check_field(string name, logic signed [31:0] want,
                                      logic signed [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endfunction

  task automatic send_request(req_kind_e kind, box_t subj, box_t clip);
    int gap;
    gap = draw_wait();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    req_type_i    <= kind;
    subj_top_i    <= subj.top;
    subj_left_i   <= subj.left;
    subj_bottom_i <= subj.bottom;
    subj_right_i  <= subj.right;
    clip_top_i    <= clip.top;
    clip_left_i   <= clip.left;
    clip_bottom_i <= clip.bottom;
    clip_right_i  <= clip.right;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    predict_pieces(kind, subj, clip);
  endtask

  task automatic draw_rects(output box_t subj, output box_t clip);
    int mode;
    int x0;
    int y0;
    int w;
    int h;
    int a;
    int b;
    mode = $urandom_range(0, 9);
    if (mode < 2) begin
      subj = box_t'({$urandom, $urandom});
      clip = box_t'({$urandom, $urandom});
    end else if (mode < 4) begin
      subj = rect(jitter(0, 8), jitter(0, 8), jitter(0, 8), jitter(0, 8));
      clip = rect(jitter(0, 8), jitter(0, 8), jitter(0, 8), jitter(0, 8));
    end else begin
      case ($urandom_range(0, 3))
        0:       x0 = -32768 + int'($urandom_range(0, 40));
        1:       x0 = 32767 - int'($urandom_range(0, 40));
        default: x0 = int'($urandom_range(0, 65535)) - 32768;
      endcase
      case ($urandom_range(0, 3))
        0:       y0 = -32768 + int'($urandom_range(0, 40));
        1:       y0 = 32767 - int'($urandom_range(0, 40));
        default: y0 = int'($urandom_range(0, 65535)) - 32768;
      endcase
      w    = $urandom_range(0, 60);
      h    = $urandom_range(0, 60);
      subj = rect(y0, x0, y0 + h, x0 + w);
      a    = x0 + int'($urandom_range(0, w));
      b    = x0 + int'($urandom_range(0, w));
      clip.left  = jitter((a < b) ? a : b, 6);
      clip.right = jitter((a < b) ? b : a, 6);
      a    = y0 + int'($urandom_range(0, h));
      b    = y0 + int'($urandom_range(0, h));
      clip.top    = jitter((a < b) ? a : b, 6);
      clip.bottom = jitter((a < b) ? b : a, 6);
    end
  endtask

  task automatic test_intersect_directed();
    send_request(REQ_INTERSECT, rect(0, 0, 99, 99), rect(10, 20, 50, 60));
    send_request(REQ_INTERSECT, rect(10, 10, 20, 20), rect(0, 0, 100, 100));
    send_request(REQ_INTERSECT, rect(0, 0, 50, 50), rect(25, 25, 75, 75));
    send_request(REQ_INTERSECT, rect(0, 0, 10, 10), rect(10, 10, 20, 20));
    send_request(REQ_INTERSECT, rect(0, 0, 10, 10), rect(0, 11, 10, 20));
    send_request(REQ_INTERSECT, rect(0, 0, 10, 10), rect(11, 0, 20, 10));
    send_request(REQ_INTERSECT, rect(-32768, -32768, 32767, 32767),
                 rect(-32768, -32768, 32767, 32767));
    send_request(REQ_INTERSECT, rect(10, 10, 0, 0), rect(0, 0, 10, 10));
  endtask

  task automatic test_split_directed();
    send_request(REQ_SPLIT, rect(0, 0, 99, 99), rect(10, 20, 50, 60));
    send_request(REQ_SPLIT, rect(10, 10, 20, 20), rect(0, 0, 100, 100));
    send_request(REQ_SPLIT, rect(5, 5, 15, 15), rect(5, 5, 15, 15));
    send_request(REQ_SPLIT, rect(-32768, -32768, -32760, -32760),
                 rect(-32768, -32768, -32760, -32760));
    send_request(REQ_SPLIT, rect(32760, 32760, 32767, 32767),
                 rect(32760, 32760, 32767, 32767));
    send_request(REQ_SPLIT, rect(0, 0, 10, 10), rect(50, 50, 60, 60));
    send_request(REQ_SPLIT, rect(0, 0, 10, 10), rect(-5, 5, 20, 20));
    send_request(REQ_SPLIT, rect(0, 0, 10, 10), rect(-5, -5, 5, 20));
    send_request(REQ_SPLIT, rect(-32768, -32768, 32767, 32767), rect(0, 0, 0, 0));
    send_request(REQ_SPLIT, rect(-32768, -32768, 32767, 32767),
                 rect(32767, -32768, -32768, 32767));
  endtask

  task automatic test_random_traffic(int count);
    box_t subj;
    box_t clip;
    repeat (count) begin
      draw_rects(subj, clip);
      send_request(req_kind_e'($urandom_range(0, 1)), subj, clip);
    end
  endtask

  task automatic test_back_to_back(int count);
    no_gaps = 1'b1;
    test_random_traffic(count);
    no_gaps = 1'b0;
  endtask

  initial begin : piece_check
    piece_t want;
    int     stall;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      stall = draw_wait();
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
      if (pending_pieces.size() == 0) begin
        $error("result beat with nothing pending: top %0d left %0d bottom %0d right %0d",
               piece_top_o, piece_left_o, piece_bottom_o, piece_right_o);
        fail_count++;
      end else begin
        want = pending_pieces.pop_front();
        check_field("piece_top", want.top, piece_top_o);
        check_field("piece_left", want.left, piece_left_o);
        check_field("piece_bottom", want.bottom, piece_bottom_o);
        check_field("piece_right", want.right, piece_right_o);
        check_field("piece_present", want.present, piece_present_o);
        check_field("last_piece", want.is_last, last_piece_o);
      end
    end
  end

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_intersect_directed();
    test_split_directed();
    test_random_traffic(150);
    test_back_to_back(60);
    test_random_traffic(150);
    in_valid_i <= 1'b0;
    while (pending_pieces.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (fail_count == 0 && pending_pieces.size() == 0) begin
      $display("** rect_clip_split: PASSED **");
    end else begin
      $display("** rect_clip_split: FAILED **");
    end
    $finish;
  end

endmodule
